[hw/rtl/bba_pkg.sv]
// Shared constants, codes and control types for the bitmap block allocator.
package bba_pkg;

   localparam int ADDR_W       = 32;
   localparam int CNT_W        = 11;
   localparam int BLOCK_SHIFT  = 12;                      // 4096-byte blocks
   localparam int STORE_BLOCKS = 1024;
   localparam int WORD_BITS    = 32;
   localparam int MAP_WORDS    = STORE_BLOCKS / WORD_BITS;
   localparam int WORD_IDX_W   = $clog2(MAP_WORDS);
   localparam int BIT_IDX_W    = $clog2(WORD_BITS);
   localparam int IDX_W        = $clog2(STORE_BLOCKS);
   localparam int CHUNK_BITS   = 8;
   localparam int CHUNK_SEL_W  = $clog2(WORD_BITS / CHUNK_BITS);
   localparam int CHUNK_W      = IDX_W - $clog2(CHUNK_BITS);
   localparam int FRAME_W      = ADDR_W - BLOCK_SHIFT;

   localparam logic CSR_REGION_BASE    = 1'b0;
   localparam logic CSR_MANAGED_BLOCKS = 1'b1;

   typedef enum logic [1:0] {
      OP_ALLOC   = 2'd0,
      OP_FREE    = 2'd1,
      OP_RELEASE = 2'd2,
      OP_RESERVE = 2'd3
   } op_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_PREP,
      ST_SIZE,
      ST_SCAN,
      ST_MARK,
      ST_FINISH
   } state_type;

   typedef struct packed {
      logic load;
      logic prep;
      logic size;
      logic scan;
      logic mark;
      logic finish;
   } cmd_type;

   typedef struct packed {
      logic is_alloc;
      logic refuse;
      logic found;
      logic scan_end;
      logic mark_last;
      logic out_room;
   } stat_type;

endpackage

[hw/rtl/bba_ctrl.sv]
// Sequencer for the bitmap block allocator.
module bba_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  bba_pkg::stat_type stat,
   output bba_pkg::cmd_type  cmd
);
   import bba_pkg::*;

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_PREP;
            end
         end
         ST_PREP: begin
            cmd.prep = 1'b1;
            state_in = ST_SIZE;
         end
         ST_SIZE: begin
            cmd.size = 1'b1;
            if (!stat.is_alloc) state_in = ST_MARK;
            else if (stat.refuse) state_in = ST_FINISH;
            else state_in = ST_SCAN;
         end
         ST_SCAN: begin
            cmd.scan = 1'b1;
            if (stat.found) state_in = ST_MARK;
            else if (stat.scan_end) state_in = ST_FINISH;
         end
         ST_MARK: begin
            cmd.mark = 1'b1;
            if (stat.mark_last) state_in = ST_FINISH;
         end
         ST_FINISH: begin
            if (stat.out_room) begin
               cmd.finish = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

endmodule

[hw/rtl/bba_datapath.sv]
// Bitmap, free counter, range arithmetic, run search and result register.
module bba_datapath (
   input  logic                        clock,
   input  logic                        reset,
   input  bba_pkg::cmd_type            cmd,
   output bba_pkg::stat_type           stat,
   input  logic [1:0]                  req_operation,
   input  logic [bba_pkg::ADDR_W-1:0]  req_address,
   input  logic [bba_pkg::CNT_W-1:0]   req_block_count,
   input  logic [bba_pkg::ADDR_W-1:0]  req_region_bytes,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic                        rsp_status,
   output logic [bba_pkg::ADDR_W-1:0]  rsp_granted_address,
   output logic [bba_pkg::ADDR_W-1:0]  rsp_used_blocks,
   input  logic                        csr_write_enable,
   input  logic                        csr_index,
   input  logic [bba_pkg::ADDR_W-1:0]  csr_write_data
);
   import bba_pkg::*;

   logic [ADDR_W-1:0]    base_ff;
   logic [CNT_W-1:0]     managed_ff;
   logic [WORD_BITS-1:0] map_ff [MAP_WORDS];
   logic [ADDR_W-1:0]    counter_ff, counter_in;
   op_type               op_ff;
   logic [ADDR_W-1:0]    addr_ff, bytes_ff, off_ff, len_ff;
   logic [CNT_W-1:0]     n_ff;
   logic                 skip_ff, refuse_ff, set_ff, ok_ff;
   logic [FRAME_W-1:0]   lo_ff, lo_in;
   logic [FRAME_W:0]     hi_ff, hi_in;
   logic [CHUNK_W-1:0]   chunk_ff;
   logic [WORD_IDX_W-1:0] word_ff;
   logic [CNT_W-1:0]     run_ff, run_in;
   logic [IDX_W-1:0]     start_ff, start_in;
   logic                 found;
   logic                 rsp_valid_ff, rsp_status_ff;
   logic [ADDR_W-1:0]    rsp_granted_ff, rsp_used_ff;

   // prep arithmetic
   logic               neg;
   logic [ADDR_W-1:0]  diff;
   logic [ADDR_W:0]    sum_end;
   // size arithmetic
   logic [FRAME_W-1:0] first, blocks, avail, cnt;
   // scan
   logic [WORD_IDX_W-1:0] rd_idx;
   logic [WORD_BITS-1:0]  rd_word, wr_word, mask;
   logic [CHUNK_BITS-1:0] chunk_bits;
   logic [CNT_W-1:0]      limit;
   logic [CNT_W:0]        next_chunk_lo;
   logic                  scan_end;

   assign neg     = addr_ff < base_ff;
   assign diff    = addr_ff - base_ff;
   assign sum_end = {1'b0, addr_ff} + {1'b0, bytes_ff};

   // Region length clipped below base is bytes - (base - addr) = bytes + diff.
   assign first  = off_ff[ADDR_W-1:BLOCK_SHIFT];
   assign blocks = len_ff[ADDR_W-1:BLOCK_SHIFT];
   assign avail  = {{(FRAME_W-CNT_W){1'b0}}, managed_ff} - first;

   always_comb begin
      cnt = '0;
      if (op_ff == OP_FREE) begin
         cnt = {{(FRAME_W-CNT_W){1'b0}}, n_ff};
      end else if (!skip_ff && first < {{(FRAME_W-CNT_W){1'b0}}, managed_ff}) begin
         cnt = (blocks < avail) ? blocks : avail;
      end
   end

   assign limit = (managed_ff > CNT_W'(STORE_BLOCKS)) ? CNT_W'(STORE_BLOCKS) : managed_ff;
   assign rd_idx = cmd.scan ? chunk_ff[CHUNK_W-1 -: WORD_IDX_W] : word_ff;
   assign rd_word = map_ff[rd_idx];
   assign chunk_bits = rd_word[chunk_ff[CHUNK_SEL_W-1:0]*CHUNK_BITS +: CHUNK_BITS];
   assign next_chunk_lo = {({1'b0, chunk_ff} + (CHUNK_W+1)'(1)), {$clog2(CHUNK_BITS){1'b0}}};
   assign scan_end = (next_chunk_lo >= {1'b0, limit}) || (&chunk_ff);

   // Run tracking over one 8-bit chunk; bits past the limit count as used.
   always_comb begin
      logic [IDX_W-1:0] idx;
      run_in   = run_ff;
      start_in = start_ff;
      found    = 1'b0;
      for (int k = 0; k < CHUNK_BITS; k++) begin
         idx = {chunk_ff, k[$clog2(CHUNK_BITS)-1:0]};
         if (!found) begin
            if (({1'b0, idx} < limit) && !chunk_bits[k]) begin
               if (run_in == '0) start_in = idx;
               run_in = run_in + CNT_W'(1);
               if (run_in == n_ff) found = 1'b1;
            end else begin
               run_in = '0;
            end
         end
      end
   end

   // Word mask for bits in [lo, hi).
   always_comb begin
      logic [FRAME_W:0] bidx;
      for (int k = 0; k < WORD_BITS; k++) begin
         bidx = {{(FRAME_W+1-IDX_W){1'b0}}, word_ff, k[BIT_IDX_W-1:0]};
         mask[k] = (bidx >= {1'b0, lo_ff}) && (bidx < hi_ff);
      end
      wr_word = set_ff ? (rd_word | mask) : (rd_word & ~mask);
   end

   always_comb begin
      counter_in = counter_ff;
      lo_in      = lo_ff;
      hi_in      = hi_ff;
      if (cmd.size) begin
         lo_in = first;
         hi_in = {1'b0, first} + {1'b0, cnt};
         if (op_ff == OP_RESERVE) counter_in = counter_ff - {{(ADDR_W-FRAME_W){1'b0}}, cnt};
         else if (op_ff != OP_ALLOC)
            counter_in = counter_ff + {{(ADDR_W-FRAME_W){1'b0}}, cnt};
      end else if (cmd.scan && found) begin
         lo_in = {{(FRAME_W-IDX_W){1'b0}}, start_in};
         hi_in = {{(FRAME_W+1-IDX_W){1'b0}}, start_in} + {{(FRAME_W+1-CNT_W){1'b0}}, n_ff};
         counter_in = counter_ff - {{(ADDR_W-CNT_W){1'b0}}, n_ff};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         base_ff    <= '0;
         managed_ff <= '0;
         counter_ff <= '0;
         for (int w = 0; w < MAP_WORDS; w++) map_ff[w] <= '1;
      end else begin
         if (csr_write_enable) begin
            case (csr_index)
               CSR_REGION_BASE:    base_ff    <= csr_write_data;
               CSR_MANAGED_BLOCKS: managed_ff <= csr_write_data[CNT_W-1:0];
               default: ;
            endcase
         end
         counter_ff <= counter_in;
         if (cmd.mark) map_ff[word_ff] <= wr_word;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         op_ff    <= op_type'(req_operation);
         addr_ff  <= req_address;
         n_ff     <= req_block_count;
         bytes_ff <= req_region_bytes;
         ok_ff    <= 1'b0;
      end
      if (cmd.prep) begin
         off_ff    <= (neg && op_ff != OP_FREE) ? '0 : diff;
         len_ff    <= neg ? (bytes_ff + diff) : bytes_ff;
         skip_ff   <= neg && (sum_end <= {1'b0, base_ff});
         refuse_ff <= (n_ff == '0) || (counter_ff < {{(ADDR_W-CNT_W){1'b0}}, n_ff});
      end
      if (cmd.size) begin
         set_ff   <= (op_ff == OP_RESERVE);
         chunk_ff <= '0;
         word_ff  <= '0;
         run_ff   <= '0;
      end
      if (cmd.scan) begin
         run_ff   <= run_in;
         start_ff <= start_in;
         chunk_ff <= chunk_ff + CHUNK_W'(1);
         if (found) begin
            set_ff <= 1'b1;
            ok_ff  <= 1'b1;
         end
      end
      if (cmd.mark) word_ff <= word_ff + WORD_IDX_W'(1);
      lo_ff <= lo_in;
      hi_ff <= hi_in;
   end

   // Result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.finish) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.finish) begin
         rsp_status_ff  <= (op_ff == OP_ALLOC) && !ok_ff;
         rsp_granted_ff <= ok_ff
            ? base_ff + {{(ADDR_W-IDX_W-BLOCK_SHIFT){1'b0}}, start_ff, {BLOCK_SHIFT{1'b0}}}
            : '0;
         rsp_used_ff    <= {{(ADDR_W-CNT_W){1'b0}}, managed_ff} - counter_ff;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_status          = rsp_status_ff;
   assign rsp_granted_address = rsp_granted_ff;
   assign rsp_used_blocks     = rsp_used_ff;

   assign stat.is_alloc  = (op_ff == OP_ALLOC);
   assign stat.refuse    = refuse_ff;
   assign stat.found     = found;
   assign stat.scan_end  = scan_end;
   assign stat.mark_last = &word_ff;
   assign stat.out_room  = !rsp_valid_ff || rsp_ready;

endmodule

[hw/rtl/bitmap_block_allocator.sv]
// Top level of the first-fit bitmap block allocator.
// Steps: free and region beats run setup, size, a pass over all 32 bitmap words, then
//   finish; allocate runs setup, size, the 8-block chunk scan, the mark pass on success.
// Throughput: one beat at a time, next beat taken the cycle after the result is loaded;
//   the search reads 8 bitmap bits per cycle, the mark pass one 32-bit word per cycle.
// Reset: synchronous; every block marked used, free counter, CSRs and result valid zero.
module bitmap_block_allocator (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  logic [1:0]                  req_operation,
   input  logic [bba_pkg::ADDR_W-1:0]  req_address,
   input  logic [bba_pkg::CNT_W-1:0]   req_block_count,
   input  logic [bba_pkg::ADDR_W-1:0]  req_region_bytes,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic                        rsp_status,
   output logic [bba_pkg::ADDR_W-1:0]  rsp_granted_address,
   output logic [bba_pkg::ADDR_W-1:0]  rsp_used_blocks,
   input  logic                        csr_write_enable,
   input  logic                        csr_index,
   input  logic [bba_pkg::ADDR_W-1:0]  csr_write_data
);
   import bba_pkg::*;

   cmd_type  cmd;   // sequencer strobes, one state per strobe
   stat_type stat;  // datapath flags steering the sequencer

   // Sequencer: idle, setup, size, scan, mark, finish.
   bba_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   // Datapath: bitmap words, counter, range math and the result register,
   // which lets the next beat start while a result waits.
   bba_datapath u_dp (
      .clock               (clock),
      .reset               (reset),
      .cmd                 (cmd),
      .stat                (stat),
      .req_operation       (req_operation),
      .req_address         (req_address),
      .req_block_count     (req_block_count),
      .req_region_bytes    (req_region_bytes),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_status          (rsp_status),
      .rsp_granted_address (rsp_granted_address),
      .rsp_used_blocks     (rsp_used_blocks),
      .csr_write_enable    (csr_write_enable),
      .csr_index           (csr_index),
      .csr_write_data      (csr_write_data)
   );

endmodule

[dv/bitmap_block_allocator_tb.sv]
// Self-checking testbench for the first-fit bitmap block allocator.
`timescale 1ns / 100ps

module bitmap_block_allocator_tb;
   import bba_pkg::*;

   localparam int BLK_BYTES = 1 << BLOCK_SHIFT;

   // per-result record: status, granted address, used-block count
   typedef struct packed {
      logic        status;
      logic [31:0] granted;
      logic [31:0] used;
   } alloc_rsp_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [1:0]  req_operation = OP_ALLOC;
   logic [31:0] req_address = '0;
   logic [10:0] req_block_count = '0;
   logic [31:0] req_region_bytes = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic        rsp_status;
   logic [31:0] rsp_granted_address;
   logic [31:0] rsp_used_blocks;
   logic        csr_write_enable = 1'b0;
   logic        csr_index = CSR_REGION_BASE;
   logic [31:0] csr_write_data = '0;

   bitmap_block_allocator dut (.*);

   initial forever #2 clock = ~clock;

   // shadow allocator state
   logic [STORE_BLOCKS-1:0] shadow_map;
   logic [31:0]             shadow_free;
   logic [31:0]             shadow_base;
   logic [10:0]             shadow_managed;

   alloc_rsp_type pending_rsp[$];
   int            error_count = 0;
   bit            rsp_stall_on = 1'b1;

   // mark one block; blocks past the store have no bit
   function automatic void shadow_set(longint unsigned idx, bit used);
      if (idx < STORE_BLOCKS) shadow_map[idx] = used;
   endfunction

   function automatic alloc_rsp_type predict_beat(op_type op, logic [31:0] addr,
                                                  logic [10:0] n, logic [31:0] bytes);
      alloc_rsp_type r;
      longint unsigned start, run, first, blocks, b, l;
      logic [31:0] off;
      bit found;
      r = '0;
      found = 0;
      start = 0;
      run = 0;
      case (op)
         OP_ALLOC: begin
            if (n != 0 && shadow_free >= 32'(n)) begin
               for (longint unsigned i = 0; i < shadow_managed; i++) begin
                  if (i < STORE_BLOCKS && !shadow_map[i]) begin
                     if (run == 0) start = i;
                     run++;
                     if (run == n) begin
                        found = 1;
                        break;
                     end
                  end else begin
                     run = 0;
                  end
               end
            end
            if (found) begin
               for (longint unsigned i = 0; i < n; i++) shadow_set(start + i, 1);
               shadow_free = shadow_free - 32'(n);
               r.granted = 32'(shadow_base + start * BLK_BYTES);
            end else begin
               r.status = 1'b1;
            end
         end
         OP_FREE: begin
            off = addr - shadow_base;             // wraps below the base
            first = off / BLK_BYTES;
            for (longint unsigned i = 0; i < n; i++) shadow_set(first + i, 0);
            shadow_free = shadow_free + 32'(n);
         end
         default: begin
            b = addr;
            l = bytes;
            if (b < shadow_base && b + l <= shadow_base) begin
               // range wholly below the base: no effect
            end else begin
               if (b < shadow_base) begin
                  l = l - (shadow_base - b);
                  b = shadow_base;
               end
               first = (b - shadow_base) / BLK_BYTES;
               blocks = l / BLK_BYTES;
               for (longint unsigned i = 0; i < blocks; i++) begin
                  if (first + i >= shadow_managed) break;
                  shadow_set(first + i, op == OP_RESERVE);
                  if (op == OP_RESERVE) shadow_free = shadow_free - 1;
                  else shadow_free = shadow_free + 1;
               end
            end
         end
      endcase
      r.used = 32'(shadow_managed) - shadow_free;
      return r;
   endfunction

   function automatic int pick_gap();
      int p;
      p = $urandom_range(0, 99);
      if (p < 50) return 0;
      if (p < 90) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // one beat on the request channel; prediction made at acceptance
   task automatic send_beat(op_type op, logic [31:0] addr, logic [10:0] n,
                            logic [31:0] bytes);
      int gap;
      // wait so that the previous beat drops valid first
      gap = pick_gap() + 1;
      repeat (gap) @(posedge clock);
      req_valid        <= 1'b1;
      req_operation    <= op;
      req_address      <= addr;
      req_block_count  <= n;
      req_region_bytes <= bytes;
      do @(posedge clock); while (!req_ready);
      pending_rsp.push_back(predict_beat(op, addr, n, bytes));
      req_valid <= 1'b0;
   endtask

   // registers change only with nothing in flight, plus drain time for the FSM
   task automatic write_csr(logic idx, logic [31:0] value);
      wait (pending_rsp.size() == 0);
      repeat (80) @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_index        <= idx;
      csr_write_data   <= value;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      if (idx == CSR_REGION_BASE) shadow_base = value;
      else shadow_managed = value[10:0];
   endtask

   // response side: random stalls, compare each beat against the oldest prediction
   always @(posedge clock) begin
      alloc_rsp_type exp_rsp;
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            if (pending_rsp.size() == 0) begin
               $display("%0t: unexpected beat status=%0b granted=%h used=%h", $time,
                        rsp_status, rsp_granted_address, rsp_used_blocks);
               error_count++;
            end else begin
               exp_rsp = pending_rsp.pop_front();
               if (rsp_status !== exp_rsp.status) begin
                  $display("%0t: status exp %0b got %0b", $time, exp_rsp.status,
                           rsp_status);
                  error_count++;
               end
               if (rsp_granted_address !== exp_rsp.granted) begin
                  $display("%0t: granted exp %h got %h", $time, exp_rsp.granted,
                           rsp_granted_address);
                  error_count++;
               end
               if (rsp_used_blocks !== exp_rsp.used) begin
                  $display("%0t: used exp %h got %h", $time, exp_rsp.used,
                           rsp_used_blocks);
                  error_count++;
               end
            end
         end
         rsp_ready <= !rsp_stall_on || (pick_gap() == 0);
      end
   end

   task automatic test_reset_state();
      // everything used at reset, nothing managed
      send_beat(OP_ALLOC, 0, 1, 0);
      send_beat(OP_ALLOC, 0, 0, 0);
   endtask

   task automatic test_directed();
      write_csr(CSR_REGION_BASE, 32'h0010_0000);
      write_csr(CSR_MANAGED_BLOCKS, 64);
      send_beat(OP_RELEASE, 32'h0010_0000, 0, 64 * BLK_BYTES + 123);  // partial block
      send_beat(OP_ALLOC, 0, 0, 0);                       // zero count refused
      send_beat(OP_ALLOC, 0, 3, 0);
      send_beat(OP_ALLOC, 0, 65, 0);                      // counter below count
      send_beat(OP_FREE, 32'h0010_1000, 1, 0);
      send_beat(OP_ALLOC, 0, 2, 0);                       // hole too small, skips ahead
      send_beat(OP_RESERVE, 32'h0000_0000, 0, 32'h0010_0000);  // ends at base: nothing
      send_beat(OP_RESERVE, 32'h000F_F000, 0, 3 * BLK_BYTES);  // clipped below base
      send_beat(OP_RESERVE, 32'h0010_0000, 0, 32'hFFFF_FFFF);  // stops at managed count
      send_beat(OP_ALLOC, 0, 1, 0);                       // no fitting run
      send_beat(OP_FREE, 32'h0000_0000, 11'd1024, 0);     // below base, wraps
      send_beat(OP_FREE, 32'hFFFF_FFFF, 11'd2047 & 11'h7FF, 32'hFFFF_FFFF);
      send_beat(OP_RELEASE, 32'hFFFF_FFFF, 0, 32'hFFFF_FFFF);
      write_csr(CSR_MANAGED_BLOCKS, 11'd2047);            // beyond the store
      write_csr(CSR_REGION_BASE, 32'hFFFF_F000);
      send_beat(OP_RELEASE, 32'hFFFF_F000, 0, 32'hFFFF_FFFF);
      send_beat(OP_ALLOC, 0, 11'd1024, 0);
      send_beat(OP_ALLOC, 0, 1, 0);                       // store full: no fitting run
      send_beat(OP_RESERVE, 32'h0, 0, 32'h0);
   endtask

   task automatic test_random(int beats, logic [10:0] managed, logic [31:0] base);
      op_type op;
      logic [31:0] addr, bytes;
      logic [10:0] n;
      int p;
      write_csr(CSR_REGION_BASE, base);
      write_csr(CSR_MANAGED_BLOCKS, managed);
      // well-formed start: give the managed range back
      send_beat(OP_RELEASE, base, 0, 32'(managed) * BLK_BYTES);
      for (int k = 0; k < beats; k++) begin
         p = $urandom_range(0, 99);
         op = (p < 45) ? OP_ALLOC : (p < 75) ? OP_FREE : (p < 88) ? OP_RELEASE
                                                                 : OP_RESERVE;
         n = ($urandom_range(0, 19) == 0) ? 11'($urandom) : 11'($urandom_range(0, 12));
         if ($urandom_range(0, 9) == 0) begin
            addr  = $urandom;
            bytes = $urandom;
         end else begin
            addr  = base + $urandom_range(0, managed + 4) * BLK_BYTES
                    + $urandom_range(0, 3);
            bytes = $urandom_range(0, 16) * BLK_BYTES + $urandom_range(0, 4095);
         end
         send_beat(op, addr, n, bytes);
      end
   endtask

   initial begin
      shadow_map     = '1;
      shadow_free    = '0;
      shadow_base    = '0;
      shadow_managed = '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_reset_state();
      test_directed();
      test_random(100, 32, 32'h8000_0000);
      test_random(100, 11'd1024, 32'h0000_0000);
      rsp_stall_on = 1'b0;                    // back-to-back stretch
      test_random(60, 200, 32'h0040_3000);
      rsp_stall_on = 1'b1;
      test_random(100, 11'd0, 32'hFFFF_0000);
      test_random(90, 11'd1500, 32'h1234_5000);
      wait (pending_rsp.size() == 0);
      repeat (200) @(posedge clock);
      if (error_count == 0) $display("bitmap_block_allocator verification clean");
      else $display("bitmap_block_allocator verification failed");
      $finish;
   end

   initial begin
      #4_000_000;
      $display("bitmap_block_allocator verification failed");
      $finish;
   end

endmodule
